// ===== design/tpi_pkg.sv =====
// Shared types and constants for the timed path interpolator.
// No dependencies; imported by tpi_div, timed_path_interpolator and the bench.
package tpi_pkg;

    localparam int MAX_NODES  = 64;
    localparam int COORD_BITS = 24;
    localparam int NODE_AW    = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int TIME_W     = 24;
    localparam int TV_W       = 25;
    localparam int LEN_W      = 32;
    localparam int FRAC_W     = 17;
    localparam int SQ_W       = 2 * (COORD_BITS + 1) + 2;
    localparam int SQ_STEPS   = SQ_W / 2;
    localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
    localparam int DIV_NW     = 56;
    localparam int DIV_DW     = LEN_W;
    localparam int MUL_W      = 32;
    localparam int RAM_W      = LEN_W + 3 * COORD_BITS;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_SET   = 2'd1,
        OP_INC   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_ADD_RD, S_ADD_LAT, S_SQ_MUL, S_SQ_ACC, S_SQRT, S_ADD_WR,
        S_OUT, S_TOT_LAT, S_TT_MUL, S_SR_RD, S_SR_MUL, S_SR_CMP, S_T0_DIV,
        S_N1_RD, S_N1_LAT, S_T1_GO, S_T1_DIV, S_N0_RD, S_N0_LAT, S_FRAC,
        S_FRAC_DIV, S_LERP_MUL, S_LERP_ACC, S_FIN
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0]             len;
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_node;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== design/tpi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/tpi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tpi_pkg for widths and control structs.
module tpi_div import tpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_ctl          i_ctl,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output t_div_sts          o_sts,
    output logic [DIV_NW-1:0] o_quot
);

    localparam int CW = $clog2(DIV_NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_NW-1:0] r_quot;
    logic [DIV_DW:0]   rem_sh;
    logic              ge;

    assign rem_sh = {r_rem, r_quot[DIV_NW-1]};
    assign ge     = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            // shift the next dividend bit in, subtract when it fits
            r_rem  <= ge ? DIV_DW'(rem_sh - {1'b0, r_dvs}) : rem_sh[DIV_DW-1:0];
            r_quot <= {r_quot[DIV_NW-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== design/timed_path_interpolator.sv =====
// Timed path interpolator: a table of up to 64 3-D nodes and a current time; each
// transaction (add node, set time, add time, query) returns the position at the current
// time, the node ending the current segment, the time, the node count and a status.
// The input is not ready while a transaction is in work. An add node also computes three
// squared differences and a 26-step square root. With two or more nodes the segment search
// visits up to 63 nodes, and up to three divisions go through the single shared 56-bit
// divider; a stalled output holds the block until the result is taken. Depends on
// tpi_pkg, tpi_ram and tpi_div.
module timed_path_interpolator import tpi_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // configuration: path_duration
    input  logic           i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    // tdata: node_x, node_y, node_z, time_value (bits 96:0), zero pad to 104
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [103:0]   i_s_tdata,
    // tuser: op
    input  logic [1:0]     i_s_tuser,
    // tdata: pos_x, pos_y, pos_z, ahead_x, ahead_y, ahead_z, time_now, count_now, pad
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [175:0]   o_m_tdata,
    // tuser: status
    output logic [1:0]     o_m_tuser
);

    localparam int CB  = COORD_BITS;
    localparam int LMW = CB + 1 + FRAC_W;

    t_state r_state, n_state;

    t_op                    r_op;
    logic signed [CB-1:0]   r_x, r_y, r_z;
    logic signed [TV_W-1:0] r_tv;
    logic [CNT_W-1:0]       r_count;
    logic [TIME_W-1:0]      r_time, r_dur;
    t_status                r_status;
    t_node                  r_na, r_nb;
    logic [SQ_W-1:0]        r_acc, r_sq_n, r_sq_r, r_sq_bit;
    logic [SQ_CNT_W-1:0]    r_k;
    logic [2*MUL_W-1:0]     r_prod, r_tt;
    logic [LEN_W-1:0]       r_total;
    logic [NODE_AW-1:0]     r_i;
    logic [TIME_W-1:0]      r_t0, r_t1;
    logic [FRAC_W-1:0]      r_frac;
    logic                   r_neg;
    logic signed [CB-1:0]   r_px, r_py, r_pz;
    logic                   r_o_valid;
    logic [175:0]           r_o_tdata;
    t_status                r_o_status;

    // RAM and shared units
    logic                ram_we;
    logic [NODE_AW-1:0]  ram_waddr, ram_raddr;
    t_node               ram_wdata, ram_rdata;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [2*MUL_W-1:0]  mul_p;
    t_div_ctl            div_ctl;
    t_div_sts            div_sts;
    logic [DIV_NW-1:0]   div_n, div_q;
    logic [DIV_DW-1:0]   div_d;

    // helpers
    logic signed [TV_W:0]   t_calc;
    logic                   t_bad;
    logic signed [CB:0]     sq_diff, lp_diff;
    logic [CB:0]            sq_mag, lp_mag;
    logic [SQ_W-1:0]        sq_try;
    logic [SQ_W:0]          len_sum;
    logic [LMW-1:0]         lp_m;
    logic [CB+1:0]          lp_q;
    logic signed [CB+1:0]   lp_pos;
    logic signed [CB-1:0]   lp_a;
    logic [TIME_W:0]        t_plus1;

    function automatic logic signed [CB-1:0] f_coord(t_node n, logic [SQ_CNT_W-1:0] k);
        logic signed [CB-1:0] c;
        case (k)
            SQ_CNT_W'(0): c = n.x;
            SQ_CNT_W'(1): c = n.y;
            default:      c = n.z;
        endcase
        return c;
    endfunction

    tpi_ram #(.WIDTH(RAM_W), .DEPTH(MAX_NODES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_sts      (div_sts),
        .o_quot     (div_q)
    );

    assign mul_p = mul_a * mul_b;

    always_comb begin
        t_calc = (r_op == OP_SET) ? (TV_W+1)'(r_tv)
                                  : $signed({2'b00, r_time}) + (TV_W+1)'(r_tv);
        t_bad  = t_calc[TV_W] || (t_calc[TV_W-1:0] > {1'b0, r_dur});

        sq_diff = (CB+1)'(f_coord('{len: '0, x: r_x, y: r_y, z: r_z}, r_k))
                  - (CB+1)'(f_coord(r_na, r_k));
        sq_mag  = sq_diff[CB] ? (CB+1)'(-sq_diff) : sq_diff;
        sq_try  = r_sq_r + r_sq_bit;
        len_sum = (SQ_W+1)'(r_na.len) + (SQ_W+1)'(r_sq_r);

        lp_a    = f_coord(r_na, r_k);
        lp_diff = (CB+1)'(f_coord(r_nb, r_k)) - (CB+1)'(lp_a);
        lp_mag  = lp_diff[CB] ? (CB+1)'(-lp_diff) : lp_diff;
        lp_m    = r_prod[LMW-1:0];
        // round toward minus infinity for a negative step
        lp_q    = r_neg ? (CB+2)'((lp_m + LMW'(65535)) >> 16) : (CB+2)'(lp_m >> 16);
        lp_pos  = (CB+2)'(lp_a) + (r_neg ? -$signed(lp_q) : $signed(lp_q));
        t_plus1 = {1'b0, r_time} + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_count[NODE_AW-1:0];
        ram_wdata     = '{len: '0, x: r_x, y: r_y, z: r_z};
        ram_raddr     = r_i;
        mul_a         = '0;
        mul_b         = '0;
        div_ctl.start = 1'b0;
        div_n         = r_prod[DIV_NW-1:0];
        div_d         = r_total;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) n_state = S_START;
            end
            S_START: begin
                n_state = S_OUT;
                if (r_op == OP_ADD && r_count < CNT_W'(MAX_NODES)) begin
                    if (r_count == '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                    end else begin
                        n_state = S_ADD_RD;
                    end
                end
            end
            S_ADD_RD: begin
                ram_raddr = NODE_AW'(r_count - 1'b1);
                n_state   = S_ADD_LAT;
            end
            S_ADD_LAT: n_state = S_SQ_MUL;
            S_SQ_MUL: begin
                mul_a   = MUL_W'(sq_mag);
                mul_b   = MUL_W'(sq_mag);
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: n_state = (r_k == SQ_CNT_W'(2)) ? S_SQRT : S_SQ_MUL;
            S_SQRT:   if (r_k == '0) n_state = S_ADD_WR;
            S_ADD_WR: begin
                ram_we        = (r_sq_r != '0);
                ram_wdata.len = len_sum[SQ_W:LEN_W] != '0 ? '1 : len_sum[LEN_W-1:0];
                n_state       = S_OUT;
            end
            S_OUT: begin
                ram_raddr = (r_count == CNT_W'(1)) ? '0 : NODE_AW'(r_count - 1'b1);
                n_state   = (r_count == '0) ? S_FIN : S_TOT_LAT;
            end
            S_TOT_LAT: n_state = (r_count == CNT_W'(1)) ? S_FIN : S_TT_MUL;
            S_TT_MUL: begin
                mul_a   = MUL_W'(t_plus1);
                mul_b   = r_total;
                n_state = S_SR_RD;
            end
            S_SR_RD:  n_state = S_SR_MUL;
            S_SR_MUL: begin
                mul_a   = MUL_W'(r_dur);
                mul_b   = ram_rdata.len;
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                if (r_i != '0 && r_tt <= r_prod) begin
                    n_state = S_SR_RD;
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = S_T0_DIV;
                end
            end
            S_T0_DIV: if (div_sts.done) n_state = S_N1_RD;
            S_N1_RD: begin
                ram_raddr = r_i + 1'b1;
                n_state   = S_N1_LAT;
            end
            S_N1_LAT: begin
                mul_a   = MUL_W'(r_dur);
                mul_b   = ram_rdata.len;
                n_state = S_T1_GO;
            end
            S_T1_GO: begin
                div_ctl.start = 1'b1;
                n_state       = S_T1_DIV;
            end
            S_T1_DIV: if (div_sts.done) n_state = S_N0_RD;
            S_N0_RD:  n_state = S_N0_LAT;
            S_N0_LAT: n_state = S_FRAC;
            S_FRAC: begin
                if (r_t1 <= r_t0 || r_time <= r_t0) begin
                    n_state = S_FIN;
                end else begin
                    div_n         = DIV_NW'({r_time - r_t0, 16'h0000});
                    div_d         = DIV_DW'(r_t1 - r_t0);
                    div_ctl.start = 1'b1;
                    n_state       = S_FRAC_DIV;
                end
            end
            S_FRAC_DIV: if (div_sts.done) n_state = S_LERP_MUL;
            S_LERP_MUL: begin
                mul_a   = MUL_W'(lp_mag);
                mul_b   = MUL_W'(r_frac);
                n_state = S_LERP_ACC;
            end
            S_LERP_ACC: n_state = (r_k == SQ_CNT_W'(2)) ? S_FIN : S_LERP_MUL;
            S_FIN:      if (!r_o_valid || i_m_tready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_time    <= '0;
            r_dur     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_dur <= i_cfg_wdata;
            if (ram_we) r_count <= r_count + 1'b1;
            if (r_state == S_START && (r_op == OP_SET || r_op == OP_INC) && !t_bad) begin
                r_time <= t_calc[TIME_W-1:0];
            end
            if (r_state == S_FIN && (!r_o_valid || i_m_tready)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= t_op'(i_s_tuser);
                r_x      <= i_s_tdata[CB-1:0];
                r_y      <= i_s_tdata[2*CB-1:CB];
                r_z      <= i_s_tdata[3*CB-1:2*CB];
                r_tv     <= i_s_tdata[3*CB+TV_W-1:3*CB];
                r_status <= ST_OK;
                r_px     <= '0;
                r_py     <= '0;
                r_pz     <= '0;
                r_nb     <= '0;
            end
            S_START: begin
                if (r_op == OP_ADD && r_count >= CNT_W'(MAX_NODES)) r_status <= ST_FULL;
                if ((r_op == OP_SET || r_op == OP_INC) && t_bad) r_status <= ST_REJECT;
            end
            S_ADD_LAT: begin
                r_na  <= ram_rdata;
                r_acc <= '0;
                r_k   <= '0;
            end
            S_SQ_MUL: r_prod <= mul_p;
            S_SQ_ACC: begin
                r_acc <= r_acc + r_prod[SQ_W-1:0];
                if (r_k == SQ_CNT_W'(2)) begin
                    r_sq_n   <= r_acc + r_prod[SQ_W-1:0];
                    r_sq_r   <= '0;
                    r_sq_bit <= SQ_W'(1) << (SQ_W - 2);
                    r_k      <= SQ_CNT_W'(SQ_STEPS - 1);
                end else begin
                    r_k      <= r_k + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_sq_n >= sq_try) begin
                    r_sq_n <= r_sq_n - sq_try;
                    r_sq_r <= (r_sq_r >> 1) + r_sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
                r_k      <= r_k - 1'b1;
            end
            S_OUT: if (r_count == '0 && r_status == ST_OK) r_status <= ST_EMPTY;
            S_TOT_LAT: begin
                r_total <= ram_rdata.len;
                r_i     <= NODE_AW'(r_count - 2'd2);
                if (r_count == CNT_W'(1)) begin
                    r_px <= ram_rdata.x;
                    r_py <= ram_rdata.y;
                    r_pz <= ram_rdata.z;
                    r_nb <= ram_rdata;
                end
            end
            S_TT_MUL: r_tt   <= mul_p;
            S_SR_MUL: r_prod <= mul_p;
            S_SR_CMP: if (r_i != '0 && r_tt <= r_prod) r_i <= r_i - 1'b1;
            S_T0_DIV: if (div_sts.done) r_t0 <= div_q[TIME_W-1:0];
            S_N1_LAT: begin
                r_nb   <= ram_rdata;
                r_prod <= mul_p;
            end
            S_T1_DIV: if (div_sts.done) r_t1 <= div_q[TIME_W-1:0];
            S_N0_LAT: begin
                r_na <= ram_rdata;
                r_k  <= '0;
            end
            S_FRAC: begin
                r_px <= r_na.x;
                r_py <= r_na.y;
                r_pz <= r_na.z;
            end
            S_FRAC_DIV: begin
                if (div_sts.done) begin
                    r_frac <= (div_q > DIV_NW'(65536)) ? FRAC_W'(65536) : div_q[FRAC_W-1:0];
                end
            end
            S_LERP_MUL: begin
                r_prod <= mul_p;
                r_neg  <= lp_diff[CB];
            end
            S_LERP_ACC: begin
                case (r_k)
                    SQ_CNT_W'(0): r_px <= lp_pos[CB-1:0];
                    SQ_CNT_W'(1): r_py <= lp_pos[CB-1:0];
                    default:      r_pz <= lp_pos[CB-1:0];
                endcase
                r_k <= r_k + 1'b1;
            end
            S_FIN: begin
                if (!r_o_valid || i_m_tready) begin
                    r_o_tdata  <= {1'b0, r_count, r_time, r_nb.z, r_nb.y, r_nb.x,
                                   r_pz, r_py, r_px};
                    r_o_status <= r_status;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_tdata;
    assign o_m_tuser  = r_o_status;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NODES))
        else $error("node count beyond table size");

    a_write_bumps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_count == $past(r_count) + 1'b1)
        else $error("node write without count update");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_status == ST_FULL) |-> r_count == CNT_W'(MAX_NODES))
        else $error("full status with room left");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_sts.busy)
        else $error("divider busy while idle");
`endif

endmodule

// ===== tb/timed_path_interpolator_tb.sv =====
// Self-checking bench for the timed path interpolator: drives node, time and query
// transactions, predicts each result in a behavioral model and compares field by field.
// Depends on tpi_pkg and timed_path_interpolator.
`timescale 1ns / 1ps

module timed_path_interpolator_tb;
    import tpi_pkg::*;

    localparam int TIMEOUT = 200000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [23:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [103:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [175:0] o_m_tdata;
    logic [1:0]   o_m_tuser;

    always #1 i_clk = ~i_clk;

    timed_path_interpolator dut (.*);

    typedef struct {
        logic [175:0] data;
        logic [1:0]   stat;
    } t_result;

    // shadow state of the path table
    longint      node_px[MAX_NODES];
    longint      node_py[MAX_NODES];
    longint      node_pz[MAX_NODES];
    longint      node_len[MAX_NODES];
    int          node_count;
    longint      cur_time;
    longint      duration;

    t_result     pending_results[$];
    int          errors;
    int          sent;
    int          received;
    int          idle_cycles;
    bit          quiet;
    bit          hold_long;
    bit          rx_stall;

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint unsigned sq_abs(longint a, longint b);
        longint unsigned d;
        d = (a >= b) ? longint'(a - b) : longint'(b - a);
        return d * d;
    endfunction

    function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic longint timing_of(int i);
        longint tot;
        tot = node_len[node_count - 1];
        if (tot == 0) return 0;
        return (duration * node_len[i]) / tot;
    endfunction

    function automatic longint blend(longint a, longint b, longint frac);
        longint p;
        p = (b - a) * frac;
        if (p >= 0) return a + (p >>> 16);
        return a - ((-p + 65535) >>> 16);
    endfunction

    function automatic t_result predict_path(t_op op, logic [103:0] d);
        t_result r;
        t_status st;
        longint x, y, z, v, t, t0, t1, fr, seg_len, c;
        longint px, py, pz, ax, ay, az;
        int i;
        st = ST_OK;
        px = 0; py = 0; pz = 0; ax = 0; ay = 0; az = 0;
        x = longint'(signed'(d[23:0]));
        y = longint'(signed'(d[47:24]));
        z = longint'(signed'(d[71:48]));
        v = longint'(signed'(d[96:72]));
        if (op == OP_ADD) begin
            if (node_count >= MAX_NODES) begin
                st = ST_FULL;
            end else if (node_count == 0) begin
                node_px[0] = x; node_py[0] = y; node_pz[0] = z;
                node_len[0] = 0;
                node_count = 1;
            end else begin
                i = node_count - 1;
                seg_len = int_sqrt(add_sat(add_sat(sq_abs(x, node_px[i]),
                                                   sq_abs(y, node_py[i])),
                                           sq_abs(z, node_pz[i])));
                if (seg_len != 0) begin
                    c = node_len[i] + seg_len;
                    if (c > 64'hFFFF_FFFF) c = 64'hFFFF_FFFF;
                    node_px[node_count] = x;
                    node_py[node_count] = y;
                    node_pz[node_count] = z;
                    node_len[node_count] = c;
                    node_count++;
                end
            end
        end else if (op == OP_SET || op == OP_INC) begin
            t = (op == OP_SET) ? v : cur_time + v;
            if (t < 0 || t > duration) st = ST_REJECT;
            else cur_time = t;
        end
        if (node_count == 0) begin
            if (st == ST_OK) st = ST_EMPTY;
        end else if (node_count == 1) begin
            px = node_px[0]; py = node_py[0]; pz = node_pz[0];
            ax = px; ay = py; az = pz;
        end else begin
            i = node_count - 2;
            while (i > 0 && cur_time < timing_of(i)) i--;
            t0 = timing_of(i);
            t1 = timing_of(i + 1);
            ax = node_px[i + 1]; ay = node_py[i + 1]; az = node_pz[i + 1];
            if (t1 <= t0 || cur_time <= t0) begin
                px = node_px[i]; py = node_py[i]; pz = node_pz[i];
            end else begin
                fr = ((cur_time - t0) << 16) / (t1 - t0);
                if (fr > 65536) fr = 65536;
                px = blend(node_px[i], ax, fr);
                py = blend(node_py[i], ay, fr);
                pz = blend(node_pz[i], az, fr);
            end
        end
        r.data = '0;
        r.data[23:0]    = px[23:0];
        r.data[47:24]   = py[23:0];
        r.data[71:48]   = pz[23:0];
        r.data[95:72]   = ax[23:0];
        r.data[119:96]  = ay[23:0];
        r.data[143:120] = az[23:0];
        r.data[167:144] = cur_time[23:0];
        r.data[174:168] = node_count[6:0];
        r.stat = st;
        return r;
    endfunction

    task automatic send_item(t_op op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic [24:0] tv);
        int gap;
        // let the previous transaction's valid drop first
        @(posedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, tv, z, y, x};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results = {pending_results, predict_path(op, {7'd0, tv, z, y, x})};
        sent++;
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (450) @(posedge i_clk);
    endtask

    task automatic write_duration(logic [23:0] val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        duration = val;
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 4000)) - 24'd2000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_empty_and_limits();
        write_duration(24'd0);
        send_item(OP_QUERY, '0, '0, '0, '0);
        send_item(OP_SET, '0, '0, '0, 25'd1);
        send_item(OP_INC, '0, '0, '0, 25'h1FFFFFF);
        send_item(OP_SET, '0, '0, '0, 25'h1000000);
        send_item(OP_INC, '0, '0, '0, '0);
        // single node, then a dropped duplicate
        send_item(OP_ADD, 24'h7FFFFF, 24'h800000, 24'h000100, '0);
        send_item(OP_ADD, 24'h7FFFFF, 24'h800000, 24'h000100, '0);
        write_duration(24'hFFFFFF);
        send_item(OP_SET, '0, '0, '0, 25'h0FFFFFF);
        send_item(OP_ADD, 24'h800000, 24'h7FFFFF, 24'h800000, '0);
        send_item(OP_SET, '0, '0, '0, 25'h0800000);
        send_item(OP_INC, '0, '0, '0, 25'h1FFFFFF);
        send_item(OP_INC, '0, '0, '0, 25'h0FFFFFF);
        send_item(OP_ADD, 24'h000000, 24'h000000, 24'h000000, '0);
        send_item(OP_QUERY, '0, '0, '0, '0);
        // shrink duration below current time so the fraction saturates
        write_duration(24'd5);
        send_item(OP_QUERY, '0, '0, '0, '0);
        send_item(OP_SET, '0, '0, '0, 25'd5);
        send_item(OP_SET, '0, '0, '0, 25'd6);
    endtask

    task automatic test_fill_table();
        write_duration(24'd1000);
        while (node_count < MAX_NODES)
            send_item(OP_ADD, rand_coord(), rand_coord(), rand_coord(), '0);
        send_item(OP_ADD, 24'h123456, 24'h654321, 24'h0, '0);
        send_item(OP_SET, '0, '0, '0, 25'd999);
        send_item(OP_QUERY, '0, '0, '0, '0);
    endtask

    task automatic test_backpressure();
        hold_long = 1'b1;
        repeat (6) send_item(OP_INC, '0, '0, '0, 25'($urandom_range(0, 3)));
        hold_long = 1'b0;
    endtask

    task automatic test_random_paths(int n_items);
        int k, op;
        logic [24:0] tv;
        k = 0;
        while (k < n_items) begin
            // each path: fresh reset-free table is impossible, so reuse but vary duration
            if (k % 110 == 0)
                write_duration((k % 220 == 0) ? 24'($urandom_range(1, 5000)) : 24'($urandom));
            op = $urandom_range(0, 9);
            tv = 25'($urandom);
            if (op < 2) begin
                send_item(OP_ADD, rand_coord(), rand_coord(), rand_coord(), '0);
            end else if (op < 5) begin
                if ($urandom_range(0, 3) != 0) tv = 25'($urandom_range(0, duration));
                send_item(OP_SET, '0, '0, '0, tv);
            end else if (op < 8) begin
                if ($urandom_range(0, 3) != 0) tv = 25'($urandom_range(0, 200)) - 25'd100;
                send_item(OP_INC, '0, '0, '0, tv);
            end else begin
                send_item(OP_QUERY, 24'($urandom), 24'($urandom), 24'($urandom), tv);
            end
            k++;
            if (k == n_items - 80) quiet = 1'b1;
        end
    endtask

    // receiver: random stalls plus one long hold-off
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_long && !rx_stall) begin
                rx_stall = 1'b1;
                i_m_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                // one hold-off only, then let the queued results drain
                hold_long = 1'b0;
                rx_stall = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 17);
                i_m_tready <= 1'b0;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            received++;
            if (pending_results.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_m_tdata[23:0] !== e.data[23:0]) begin
                    $error("pos_x exp %h got %h", e.data[23:0], o_m_tdata[23:0]); errors++;
                end
                if (o_m_tdata[47:24] !== e.data[47:24]) begin
                    $error("pos_y exp %h got %h", e.data[47:24], o_m_tdata[47:24]); errors++;
                end
                if (o_m_tdata[71:48] !== e.data[71:48]) begin
                    $error("pos_z exp %h got %h", e.data[71:48], o_m_tdata[71:48]); errors++;
                end
                if (o_m_tdata[95:72] !== e.data[95:72]) begin
                    $error("ahead_x exp %h got %h", e.data[95:72], o_m_tdata[95:72]); errors++;
                end
                if (o_m_tdata[119:96] !== e.data[119:96]) begin
                    $error("ahead_y exp %h got %h", e.data[119:96], o_m_tdata[119:96]);
                    errors++;
                end
                if (o_m_tdata[143:120] !== e.data[143:120]) begin
                    $error("ahead_z exp %h got %h", e.data[143:120], o_m_tdata[143:120]);
                    errors++;
                end
                if (o_m_tdata[167:144] !== e.data[167:144]) begin
                    $error("time_now exp %0d got %0d", e.data[167:144], o_m_tdata[167:144]);
                    errors++;
                end
                if (o_m_tdata[174:168] !== e.data[174:168]) begin
                    $error("count_now exp %0d got %0d", e.data[174:168], o_m_tdata[174:168]);
                    errors++;
                end
                if (o_m_tuser !== e.stat) begin
                    $error("status exp %0d got %0d", e.stat, o_m_tuser); errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        errors = 0; sent = 0; received = 0; idle_cycles = 0;
        quiet = 0; hold_long = 0; rx_stall = 0;
        node_count = 0; cur_time = 0; duration = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_limits();
        test_fill_table();
        test_backpressure();
        test_random_paths(560);
        drain_results();
        $display("Covered %0d transactions: empty path, single node, duplicates, full table,",
                 sent);
        $display("time rejects, duration changes and random paths; %0d results checked.",
                 received);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tpi_pkg.sv
design/tpi_ram.sv
design/tpi_div.sv
design/timed_path_interpolator.sv
tb/timed_path_interpolator_tb.sv
